// ===== design/positional_array_list_macros.svh =====
// Assertion macros for the positional array list
`ifndef POSITIONAL_ARRAY_LIST_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_MACROS_SVH

`ifndef ASSERT_OFF
`define PAL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PAL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PAL_ASSERT(label, prop, msg)
`define PAL_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== design/pal_pkg.sv =====
`default_nettype none
package pal_pkg;

    localparam int CAPACITY = 128;
    localparam int WORD_W   = 32;
    localparam int CMD_W    = 3;
    localparam int POS_W    = 7;
    localparam int STAT_W   = 2;
    localparam int OUT_CNT_W = 8;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int GROUP    = 8;
    localparam int NGROUPS  = (CAPACITY + GROUP - 1) / GROUP;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_END   = 3'd1,
        CMD_INS_AT    = 3'd2,
        CMD_REM_FRONT = 3'd3,
        CMD_REM_END   = 3'd4,
        CMD_REM_AT    = 3'd5
    } cmd_e;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RANGE = 2'd3
    } status_e;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FOLD,
        ST_LAST
    } state_e;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [WORD_W-1:0] entry_value;
        logic [POS_W-1:0]  position;
    } pal_in_t;

    typedef struct packed {
        logic [WORD_W-1:0]    removed_value;
        logic [STAT_W-1:0]    status;
        logic [OUT_CNT_W-1:0] entry_count;
    } pal_out_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic              go;
        logic              ins;
        logic              rem;
        logic [CNT_W-1:0]  at;
        logic [CNT_W-1:0]  cnt;
        logic [WORD_W-1:0] value;
    } pal_bcast_t;

endpackage
`default_nettype wire

// ===== design/pal_cell.sv =====
`default_nettype none
module pal_cell (
    input  wire logic                      clk,
    input  wire pal_pkg::pal_bcast_t       bc,
    input  wire logic [pal_pkg::IDX_W-1:0] index,
    input  wire logic [pal_pkg::WORD_W-1:0] left_value,
    input  wire logic [pal_pkg::WORD_W-1:0] right_value,
    output logic      [pal_pkg::WORD_W-1:0] value,
    output logic      [pal_pkg::WORD_W-1:0] pick
);
    import pal_pkg::*;

    logic [WORD_W-1:0] value_reg, value_next;
    logic [WORD_W-1:0] pick_reg, pick_next;
    logic [CNT_W-1:0]  idx;

    assign idx = CNT_W'(index);

    always_comb
    begin
        value_next = value_reg;
        pick_next  = pick_reg;
        if (bc.go)
        begin
            pick_next = '0;
            if (bc.ins)
            begin
                if (idx == bc.at)
                    value_next = bc.value;
                else if (idx > bc.at && idx <= bc.cnt)
                    value_next = left_value;
            end
            else if (bc.rem)
            begin
                if (idx == bc.at)
                    pick_next = value_reg;
                if (idx >= bc.at && (idx + CNT_W'(1)) < bc.cnt)
                    value_next = right_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        pick_reg  <= pick_next;
    end

    assign value = value_reg;
    assign pick  = pick_reg;

endmodule
`default_nettype wire

// ===== design/positional_array_list.sv =====
// Channel   Handshake           Payload     Notes
// item      start / busy        pal_in_t    taken when start & !busy
// result    done (one cycle)    pal_out_t   no back-pressure
//
// One word at a time: busy holds off the next word until done rises. The cells shift in the
// accept cycle, then the removed value is collected from the 128 cells through a two-level
// registered OR tree. busy is high in FOLD and LAST; done rises on the return to IDLE.
// Reset clears the state, the entry count and done only; cell contents are undefined until written.
// The receiver cannot stall: done stands for exactly one cycle; result holds until the next one.
`default_nettype none
`include "positional_array_list_macros.svh"
module positional_array_list (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire pal_pkg::pal_in_t  item,
    output logic                   done,
    output pal_pkg::pal_out_t      result
);
    import pal_pkg::*;

    state_e state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic done_reg, done_next;
    pal_out_t result_reg, result_next;
    logic [WORD_W-1:0] group_reg [NGROUPS];
    logic [WORD_W-1:0] group_next [NGROUPS];

    logic accept;
    pal_bcast_t bc;
    logic [WORD_W-1:0] cell_value [CAPACITY];
    logic [WORD_W-1:0] cell_pick [CAPACITY];
    logic [CNT_W-1:0] pos_ext;
    logic full, empty;

    assign accept  = start && !busy;
    assign busy    = (state_reg != ST_IDLE);
    assign pos_ext = CNT_W'(item.position);
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign empty   = (count_reg == '0);

    // command decode
    always_comb
    begin
        bc          = '0;
        bc.go       = accept;
        bc.cnt      = count_reg;
        bc.value    = item.entry_value;
        status_next = STAT_OK;
        case (item.command)
            CMD_INS_FRONT: bc.at = '0;
            CMD_INS_END:   bc.at = count_reg;
            CMD_INS_AT:    bc.at = pos_ext;
            CMD_REM_FRONT: bc.at = '0;
            CMD_REM_END:   bc.at = count_reg - CNT_W'(1);
            CMD_REM_AT:    bc.at = pos_ext;
            default:       bc.at = '0;
        endcase
        case (item.command)
            CMD_INS_FRONT, CMD_INS_END, CMD_INS_AT:
            begin
                if (full)
                    status_next = STAT_FULL;
                else if (bc.at > count_reg)
                    status_next = STAT_RANGE;
                else
                    bc.ins = 1'b1;
            end
            CMD_REM_FRONT, CMD_REM_END, CMD_REM_AT:
            begin
                if (empty)
                    status_next = STAT_EMPTY;
                else if (bc.at >= count_reg)
                    status_next = STAT_RANGE;
                else
                    bc.rem = 1'b1;
            end
            default: status_next = STAT_OK;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept && bc.ins)
            count_next = count_reg + CNT_W'(1);
        else if (accept && bc.rem)
            count_next = count_reg - CNT_W'(1);
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [WORD_W-1:0] left_w, right_w;
            if (gi == 0)
            begin : g_first
                assign left_w = '0;
            end
            else
            begin : g_mid_l
                assign left_w = cell_value[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_w = '0;
            end
            else
            begin : g_mid_r
                assign right_w = cell_value[gi+1];
            end
            pal_cell u_cell (
                .clk         (clk),
                .bc          (bc),
                .index       (IDX_W'(gi)),
                .left_value  (left_w),
                .right_value (right_w),
                .value       (cell_value[gi]),
                .pick        (cell_pick[gi])
            );
        end
    endgenerate

    // first level of the OR tree
    always_comb
    begin
        for (int g = 0; g < NGROUPS; g++)
        begin
            group_next[g] = '0;
            for (int k = 0; k < GROUP; k++)
            begin
                if (g * GROUP + k < CAPACITY)
                    group_next[g] = group_next[g] | cell_pick[g * GROUP + k];
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                state_next = ST_LAST;
            end
            ST_LAST:
            begin
                state_next                = ST_IDLE;
                done_next                 = 1'b1;
                result_next.removed_value = '0;
                for (int g = 0; g < NGROUPS; g++)
                    result_next.removed_value = result_next.removed_value | group_reg[g];
                result_next.status      = status_reg;
                result_next.entry_count = OUT_CNT_W'(count_reg);
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            status_reg <= status_next;
        if (state_reg == ST_FOLD)
            group_reg <= group_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `PAL_ASSERT(a_count_bound, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `PAL_ASSERT(a_done_after_last, done_reg |-> $past(state_reg == ST_LAST), "stray done")
    `PAL_ASSERT(a_fold_to_last, (state_reg == ST_FOLD) |=> (state_reg == ST_LAST), "fold stuck")
    `PAL_ASSERT(a_count_reported, done_reg |-> (result_reg.entry_count == OUT_CNT_W'(count_reg)), "count mismatch")
    `PAL_ASSERT(a_count_step, (!accept) |=> $stable(count_reg), "count moved without a word")

endmodule
`default_nettype wire
